/* src/assert_macros.svh */
// Assertion macros shared by the windowed loss peak filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* src/wlpf_pkg.sv */
// Types, constants and helpers shared by the windowed loss peak filter.
package wlpf_pkg;

    localparam int LOSS_W      = 17;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WIN  = 1'b1;

    localparam logic [WIN_W-1:0] RST_SHORT_WIN = 16'd1000;
    localparam logic [WIN_W-1:0] RST_LONG_WIN  = 16'd10000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRD,
        ST_SCHK,
        ST_SAPP,
        ST_LRD,
        ST_LCHK,
        ST_NRD,
        ST_NCHK,
        ST_DIV,
        ST_PUSH,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic s_rd;
        logic s_drop;
        logic s_app;
        logic l_rd_head;
        logic l_drop;
        logic l_rd_new;
        logic div_start;
        logic push;
        logic scan_clr;
        logic scan_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic s_empty;
        logic s_full;
        logic s_stale;
        logic l_empty;
        logic l_stale;
        logic n_stale;
        logic div_done;
        logic scan_end;
    } t_stat;

    // An entry is stale when its unsigned age exceeds the window.
    function automatic logic is_stale(input logic [TIME_W-1:0] t,
                                      input logic [TIME_W-1:0] now,
                                      input logic [WIN_W-1:0]  win);
        logic [TIME_W-1:0] age;
        age = now - t;
        return age > TIME_W'(win);
    endfunction

endpackage

/* src/wlpf_div.sv */
// Restoring divider, one quotient bit per cycle, for the interval average.
module wlpf_div #(
    parameter int NW = 23,
    parameter int DW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient
);
    localparam int CNTW = $clog2(NW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_den;

    logic [DW:0]     trial;
    logic            ge;
    logic [DW-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_quo[NW-1]};
        ge    = trial >= {1'b0, r_den};
        n_rem = ge ? DW'(trial - {1'b0, r_den}) : DW'(trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/wlpf_dp.sv */
// Datapath: sample and average stores, their pointers, the divider and the peak scan.
module wlpf_dp #(
    parameter int SHORT_DEPTH = 64,
    parameter int LONG_DEPTH  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  wlpf_pkg::t_cmd                i_cmd,
    input  logic [wlpf_pkg::LOSS_W-1:0]   i_loss,
    input  logic [wlpf_pkg::TIME_W-1:0]   i_now,
    input  logic [wlpf_pkg::WIN_W-1:0]    i_short_win,
    input  logic [wlpf_pkg::WIN_W-1:0]    i_long_win,
    output wlpf_pkg::t_stat               o_stat,
    output logic [wlpf_pkg::LOSS_W-1:0]   o_peak
);
    import wlpf_pkg::*;

    localparam int SIW  = $clog2(SHORT_DEPTH);
    localparam int SCW  = $clog2(SHORT_DEPTH + 1);
    localparam int LIW  = $clog2(LONG_DEPTH);
    localparam int LCW  = $clog2(LONG_DEPTH + 1);
    localparam int SUMW = LOSS_W + SIW;

    // Stores
    logic [LOSS_W-1:0] r_s_loss_mem [SHORT_DEPTH];
    logic [TIME_W-1:0] r_s_time_mem [SHORT_DEPTH];
    logic [LOSS_W-1:0] r_l_loss_mem [LONG_DEPTH];
    logic [TIME_W-1:0] r_l_time_mem [LONG_DEPTH];

    // Read data
    logic [LOSS_W-1:0] r_s_lrd;
    logic [TIME_W-1:0] r_s_trd;
    logic [LOSS_W-1:0] r_l_lrd;
    logic [TIME_W-1:0] r_l_trd;

    // Pointers and running sum
    logic [SIW-1:0]    r_s_head;
    logic [SCW-1:0]    r_s_cnt;
    logic [SUMW-1:0]   r_s_sum;
    logic [LIW-1:0]    r_l_head;
    logic [LCW-1:0]    r_l_cnt;

    // Item being processed and scan state
    logic [LOSS_W-1:0] r_loss;
    logic [TIME_W-1:0] r_now;
    logic [LCW-1:0]    r_scan_idx;
    logic              r_scan_vld;
    logic [LOSS_W-1:0] r_peak;

    logic [SCW:0]      s_pos_sum;
    logic [SIW-1:0]    s_pos;
    logic [SIW-1:0]    s_head_inc;
    logic [LCW:0]      l_pos_sum;
    logic [LIW-1:0]    l_pos;
    logic [LCW:0]      l_new_sum;
    logic [LIW-1:0]    l_new;
    logic [LCW:0]      l_scan_sum;
    logic [LIW-1:0]    l_scan;
    logic [LIW-1:0]    l_head_inc;
    logic [LIW-1:0]    l_raddr;
    logic              l_ren;
    logic              div_done;
    logic [SUMW-1:0]   quotient;

    always_comb begin
        s_pos_sum = (SCW+1)'(r_s_head) + (SCW+1)'(r_s_cnt);
        if (s_pos_sum >= (SCW+1)'(SHORT_DEPTH)) begin
            s_pos_sum = s_pos_sum - (SCW+1)'(SHORT_DEPTH);
        end
        s_pos      = s_pos_sum[SIW-1:0];
        s_head_inc = (r_s_head == SIW'(SHORT_DEPTH - 1)) ? '0 : r_s_head + 1'b1;

        l_pos_sum = (LCW+1)'(r_l_head) + (LCW+1)'(r_l_cnt);
        if (l_pos_sum >= (LCW+1)'(LONG_DEPTH)) begin
            l_pos_sum = l_pos_sum - (LCW+1)'(LONG_DEPTH);
        end
        l_pos = l_pos_sum[LIW-1:0];

        // The newest entry is only looked up while the list holds at least one.
        l_new_sum = (LCW+1)'(r_l_head) + (LCW+1)'(r_l_cnt) - 1'b1;
        if (l_new_sum >= (LCW+1)'(LONG_DEPTH)) begin
            l_new_sum = l_new_sum - (LCW+1)'(LONG_DEPTH);
        end
        l_new = l_new_sum[LIW-1:0];

        l_scan_sum = (LCW+1)'(r_l_head) + (LCW+1)'(r_scan_idx);
        if (l_scan_sum >= (LCW+1)'(LONG_DEPTH)) begin
            l_scan_sum = l_scan_sum - (LCW+1)'(LONG_DEPTH);
        end
        l_scan = l_scan_sum[LIW-1:0];

        l_head_inc = (r_l_head == LIW'(LONG_DEPTH - 1)) ? '0 : r_l_head + 1'b1;

        if (i_cmd.l_rd_new) begin
            l_raddr = l_new;
        end else if (i_cmd.scan_rd) begin
            l_raddr = l_scan;
        end else begin
            l_raddr = r_l_head;
        end
        l_ren = i_cmd.l_rd_head | i_cmd.l_rd_new | i_cmd.scan_rd;
    end

    // Short store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.s_app) begin
            r_s_loss_mem[s_pos] <= r_loss;
            r_s_time_mem[s_pos] <= r_now;
        end
        if (i_cmd.s_rd) begin
            r_s_lrd <= r_s_loss_mem[r_s_head];
            r_s_trd <= r_s_time_mem[r_s_head];
        end
    end

    // Long store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_l_loss_mem[l_pos] <= quotient[LOSS_W-1:0];
            r_l_time_mem[l_pos] <= r_now;
        end
        if (l_ren) begin
            r_l_lrd <= r_l_loss_mem[l_raddr];
            r_l_trd <= r_l_time_mem[l_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_loss <= i_loss;
            r_now  <= i_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_head <= '0;
            r_s_cnt  <= '0;
            r_s_sum  <= '0;
            r_l_head <= '0;
            r_l_cnt  <= '0;
        end else begin
            if (i_cmd.s_drop) begin
                r_s_sum  <= r_s_sum - SUMW'(r_s_lrd);
                r_s_head <= s_head_inc;
                r_s_cnt  <= r_s_cnt - 1'b1;
            end else if (i_cmd.s_app) begin
                r_s_sum <= r_s_sum + SUMW'(r_loss);
                r_s_cnt <= r_s_cnt + 1'b1;
            end else if (i_cmd.push) begin
                r_s_sum  <= '0;
                r_s_head <= '0;
                r_s_cnt  <= '0;
            end

            if (i_cmd.l_drop) begin
                r_l_head <= l_head_inc;
                r_l_cnt  <= r_l_cnt - 1'b1;
            end else if (i_cmd.push) begin
                // A full list loses its oldest entry to the new one.
                if (r_l_cnt == LCW'(LONG_DEPTH)) begin
                    r_l_head <= l_head_inc;
                end else begin
                    r_l_cnt <= r_l_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_scan_vld <= 1'b0;
            r_peak     <= '0;
        end else begin
            r_scan_vld <= i_cmd.scan_rd;
            if (i_cmd.scan_clr) begin
                r_scan_idx <= '0;
                r_peak     <= '0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                if (r_scan_vld && (r_l_lrd > r_peak)) begin
                    r_peak <= r_l_lrd;
                end
            end
        end
    end

    wlpf_div #(
        .NW (SUMW),
        .DW (SCW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_s_sum),
        .i_divisor  (r_s_cnt),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        o_stat.s_empty  = (r_s_cnt == '0);
        o_stat.s_full   = (r_s_cnt == SCW'(SHORT_DEPTH));
        o_stat.s_stale  = is_stale(r_s_trd, r_now, i_short_win);
        o_stat.l_empty  = (r_l_cnt == '0);
        o_stat.l_stale  = is_stale(r_l_trd, r_now, i_long_win);
        o_stat.n_stale  = is_stale(r_l_trd, r_now, i_short_win);
        o_stat.div_done = div_done;
        o_stat.scan_end = (r_scan_idx == r_l_cnt);
    end

    assign o_peak = r_peak;

endmodule

/* src/wlpf_ctrl.sv */
// Controller state machine that sequences eviction, averaging and the peak scan.
module wlpf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_out_free,
    input  wlpf_pkg::t_stat i_stat,
    output wlpf_pkg::t_cmd  o_cmd
);
    import wlpf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SRD;
            end
            ST_SRD: begin
                n_state = i_stat.s_empty ? ST_SAPP : ST_SCHK;
            end
            ST_SCHK: begin
                n_state = i_stat.s_stale ? ST_SRD : ST_SAPP;
            end
            ST_SAPP: begin
                n_state = ST_LRD;
            end
            ST_LRD: begin
                n_state = i_stat.l_empty ? ST_DIV : ST_LCHK;
            end
            ST_LCHK: begin
                n_state = i_stat.l_stale ? ST_LRD : ST_NRD;
            end
            ST_NRD: begin
                n_state = ST_NCHK;
            end
            ST_NCHK: begin
                n_state = i_stat.n_stale ? ST_DIV : ST_SCAN;
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_stat.scan_end) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.accept   = i_in_valid;
            end
            ST_SRD: begin
                o_cmd.s_rd = !i_stat.s_empty;
            end
            ST_SCHK: begin
                // A stale sample goes, and so does the oldest one of a full list.
                o_cmd.s_drop = i_stat.s_stale | i_stat.s_full;
            end
            ST_SAPP: begin
                o_cmd.s_app = 1'b1;
            end
            ST_LRD: begin
                o_cmd.l_rd_head = !i_stat.l_empty;
                o_cmd.div_start = i_stat.l_empty;
            end
            ST_LCHK: begin
                o_cmd.l_drop = i_stat.l_stale;
            end
            ST_NRD: begin
                o_cmd.l_rd_new = 1'b1;
            end
            ST_NCHK: begin
                o_cmd.div_start = i_stat.n_stale;
                o_cmd.scan_clr  = !i_stat.n_stale;
            end
            ST_DIV: begin
                o_cmd = '0;
            end
            ST_PUSH: begin
                o_cmd.push     = 1'b1;
                o_cmd.scan_clr = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = !i_stat.scan_end;
            end
            ST_DONE: begin
                o_cmd.out_load = i_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* src/windowed_loss_peak_filter.sv */
// Top level of the windowed loss peak filter: ports, configuration, result register.
//
// Channel   Direction  Beat contents (lowest bit first)
// s_axis    in         loss_sample[16:0], now_ms[48:17], zero fill to 56 bits
// m_axis    out        peak_loss[16:0], zero fill to 24 bits
// cfg       in         i_cfg_index selects the register, i_cfg_data[15:0] is written
//
// One input beat yields one output beat. Its processing time grows with each evicted raw
// sample or average and with each stored average read by the peak scan; the serial divider
// and the push add to it when a new average is formed, and so does any wait for the output
// register to free up.
// Reset is synchronous and active low; the stores need no clearing pass. s_axis_tready is
// high only while the block is idle; a finished result waits in the output register.
`include "assert_macros.svh"

module windowed_loss_peak_filter #(
    parameter int SHORT_DEPTH = 64,
    parameter int LONG_DEPTH  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: loss_sample (17), now_ms (32), zero fill (7).
    input  logic [wlpf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: peak_loss (17), zero fill (7).
    output logic [wlpf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wlpf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wlpf_pkg::WIN_W-1:0]          i_cfg_data
);
    import wlpf_pkg::*;

    // Window registers, written through the configuration channel.
    logic [WIN_W-1:0]  r_short_win;
    logic [WIN_W-1:0]  r_long_win;

    // Output register, which decouples the result from the next item.
    logic              r_out_vld;
    logic [LOSS_W-1:0] r_out_data;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [LOSS_W-1:0] w_peak;
    logic              w_out_free;

    // The configuration channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_win <= RST_SHORT_WIN;
            r_long_win  <= RST_LONG_WIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SHORT_WIN: r_short_win <= i_cfg_data;
                REG_LONG_WIN:  r_long_win  <= i_cfg_data;
                default: begin
                    r_short_win <= r_short_win;
                end
            endcase
        end
    end

    // The result register may be reloaded when it is empty or being taken.
    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.out_load) begin
            r_out_data <= w_peak;
        end
    end

    assign s_axis_tready = w_cmd.in_ready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W - LOSS_W){1'b0}}, r_out_data};

    wlpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wlpf_dp #(
        .SHORT_DEPTH (SHORT_DEPTH),
        .LONG_DEPTH  (LONG_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_loss      (s_axis_tdata[LOSS_W-1:0]),
        .i_now       (s_axis_tdata[LOSS_W+TIME_W-1:LOSS_W]),
        .i_short_win (r_short_win),
        .i_long_win  (r_long_win),
        .o_stat      (w_stat),
        .o_peak      (w_peak)
    );

    // A result is never loaded while the block is idle and taking beats.
    `ASSERT_IMPL(a_ready_not_loading, i_clk, i_rst_n, w_cmd.in_ready, !w_cmd.out_load)
    // A result is loaded only where it cannot overwrite one still waiting.
    `ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, w_cmd.out_load, !r_out_vld || m_axis_tready)
    // Once a beat is taken, the block is busy in the following cycle.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // Loading the result register always presents a beat next cycle.
    `ASSERT_NEXT(a_result_after_load, i_clk, i_rst_n, w_cmd.out_load, m_axis_tvalid)

endmodule
